// ===== rtl/lcd_4bit_write_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// lcd_4bit_write_sequencer_assert.svh
// Assertion macros used by the LCD write sequencer step module (lcd4w_seq).
// ----------------------------------------------------------------------------
`ifndef LCD_4BIT_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_4BIT_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LCD4W_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd4w assertion failed");

// next-cycle implication
`define LCD4W_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd4w assertion failed");

`endif

// ===== rtl/lcd4w_pkg.sv =====
// ----------------------------------------------------------------------------
// lcd4w_pkg
// Types, codes and the microcode ROM of the 4-bit LCD write sequencer.
// ----------------------------------------------------------------------------
package lcd4w_pkg;

    // request opcodes
    localparam logic [1:0] OP_INSTR = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_LINE_COUNT = 2'd0;
    localparam logic [1:0] REG_FUNC_SET   = 2'd1;
    localparam logic [1:0] REG_DISP_CTL   = 2'd2;
    localparam logic [1:0] REG_ENTRY_MODE = 2'd3;

    localparam int AddrW = 4;

    localparam logic [7:0] SetDdram  = 8'h80;
    localparam logic [7:0] ClearCmd  = 8'h01;
    localparam logic [7:0] DispOffMask = 8'hFB;
    localparam logic [6:0] Row1Off = 7'h00;
    localparam logic [6:0] Row2Off = 7'h40;
    localparam logic [6:0] Row3Off = 7'h14;
    localparam logic [6:0] Row4Off = 7'h54;

    // nibble source
    localparam logic [2:0] NIB_HI   = 3'd0;
    localparam logic [2:0] NIB_LO   = 3'd1;
    localparam logic [2:0] NIB_ZERO = 3'd2;
    localparam logic [2:0] NIB_3    = 3'd3;
    localparam logic [2:0] NIB_2    = 3'd4;

    // byte source
    localparam logic [2:0] BYTE_CMD   = 3'd0;
    localparam logic [2:0] BYTE_FSET  = 3'd1;
    localparam logic [2:0] BYTE_DOFF  = 3'd2;
    localparam logic [2:0] BYTE_ENTRY = 3'd3;
    localparam logic [2:0] BYTE_CLEAR = 3'd4;
    localparam logic [2:0] BYTE_DCTL  = 3'd5;

    // hold time select
    localparam logic [2:0] HOLD_100   = 3'd0;
    localparam logic [2:0] HOLD_50    = 3'd1;
    localparam logic [2:0] HOLD_50X   = 3'd2;
    localparam logic [2:0] HOLD_2050  = 3'd3;
    localparam logic [2:0] HOLD_20000 = 3'd4;
    localparam logic [2:0] HOLD_5000  = 3'd5;
    localparam logic [2:0] HOLD_200   = 3'd6;

    // program entry points
    localparam logic [5:0] PcByte = 6'd0;
    localparam logic [5:0] PcInit = 6'd6;
    localparam logic [5:0] PcLast = 6'd46;

    typedef struct packed {
        logic [2:0] line_count;
        logic [7:0] function_set_cmd;
        logic [7:0] display_control_cmd;
        logic [7:0] entry_mode_cmd;
    } t_cfg;

    typedef struct packed {
        logic [2:0] nib_sel;
        logic [2:0] byte_sel;
        logic       en;
        logic [2:0] hold_sel;
        logic       last;
    } t_uop;

    function automatic t_uop uop_rom(input logic [5:0] addr);
        t_uop u;
        case (addr)
            // byte write: high nibble pulse, low nibble pulse
            6'd0:  u = '{NIB_HI, BYTE_CMD, 1'b0, HOLD_100, 1'b0};
            6'd1:  u = '{NIB_HI, BYTE_CMD, 1'b1, HOLD_100, 1'b0};
            6'd2:  u = '{NIB_HI, BYTE_CMD, 1'b0, HOLD_50,  1'b0};
            6'd3:  u = '{NIB_LO, BYTE_CMD, 1'b0, HOLD_100, 1'b0};
            6'd4:  u = '{NIB_LO, BYTE_CMD, 1'b1, HOLD_100, 1'b0};
            6'd5:  u = '{NIB_LO, BYTE_CMD, 1'b0, HOLD_50X, 1'b1};
            // init: power-up wait and 8-bit wake-up nibbles
            6'd6:  u = '{NIB_ZERO, BYTE_CMD, 1'b0, HOLD_20000, 1'b0};
            6'd7:  u = '{NIB_3, BYTE_CMD, 1'b0, HOLD_100,  1'b0};
            6'd8:  u = '{NIB_3, BYTE_CMD, 1'b1, HOLD_100,  1'b0};
            6'd9:  u = '{NIB_3, BYTE_CMD, 1'b0, HOLD_5000, 1'b0};
            6'd10: u = '{NIB_3, BYTE_CMD, 1'b1, HOLD_100,  1'b0};
            6'd11: u = '{NIB_3, BYTE_CMD, 1'b0, HOLD_200,  1'b0};
            6'd12: u = '{NIB_3, BYTE_CMD, 1'b1, HOLD_100,  1'b0};
            6'd13: u = '{NIB_3, BYTE_CMD, 1'b0, HOLD_5000, 1'b0};
            // switch to 4-bit
            6'd14: u = '{NIB_2, BYTE_CMD, 1'b0, HOLD_100, 1'b0};
            6'd15: u = '{NIB_2, BYTE_CMD, 1'b1, HOLD_100, 1'b0};
            6'd16: u = '{NIB_2, BYTE_CMD, 1'b0, HOLD_50,  1'b0};
            // function set
            6'd17: u = '{NIB_HI, BYTE_FSET, 1'b0, HOLD_100, 1'b0};
            6'd18: u = '{NIB_HI, BYTE_FSET, 1'b1, HOLD_100, 1'b0};
            6'd19: u = '{NIB_HI, BYTE_FSET, 1'b0, HOLD_50,  1'b0};
            6'd20: u = '{NIB_LO, BYTE_FSET, 1'b0, HOLD_100, 1'b0};
            6'd21: u = '{NIB_LO, BYTE_FSET, 1'b1, HOLD_100, 1'b0};
            6'd22: u = '{NIB_LO, BYTE_FSET, 1'b0, HOLD_50,  1'b0};
            // display off
            6'd23: u = '{NIB_HI, BYTE_DOFF, 1'b0, HOLD_100, 1'b0};
            6'd24: u = '{NIB_HI, BYTE_DOFF, 1'b1, HOLD_100, 1'b0};
            6'd25: u = '{NIB_HI, BYTE_DOFF, 1'b0, HOLD_50,  1'b0};
            6'd26: u = '{NIB_LO, BYTE_DOFF, 1'b0, HOLD_100, 1'b0};
            6'd27: u = '{NIB_LO, BYTE_DOFF, 1'b1, HOLD_100, 1'b0};
            6'd28: u = '{NIB_LO, BYTE_DOFF, 1'b0, HOLD_50,  1'b0};
            // entry mode
            6'd29: u = '{NIB_HI, BYTE_ENTRY, 1'b0, HOLD_100, 1'b0};
            6'd30: u = '{NIB_HI, BYTE_ENTRY, 1'b1, HOLD_100, 1'b0};
            6'd31: u = '{NIB_HI, BYTE_ENTRY, 1'b0, HOLD_50,  1'b0};
            6'd32: u = '{NIB_LO, BYTE_ENTRY, 1'b0, HOLD_100, 1'b0};
            6'd33: u = '{NIB_LO, BYTE_ENTRY, 1'b1, HOLD_100, 1'b0};
            6'd34: u = '{NIB_LO, BYTE_ENTRY, 1'b0, HOLD_50,  1'b0};
            // clear, long settle
            6'd35: u = '{NIB_HI, BYTE_CLEAR, 1'b0, HOLD_100,  1'b0};
            6'd36: u = '{NIB_HI, BYTE_CLEAR, 1'b1, HOLD_100,  1'b0};
            6'd37: u = '{NIB_HI, BYTE_CLEAR, 1'b0, HOLD_50,   1'b0};
            6'd38: u = '{NIB_LO, BYTE_CLEAR, 1'b0, HOLD_100,  1'b0};
            6'd39: u = '{NIB_LO, BYTE_CLEAR, 1'b1, HOLD_100,  1'b0};
            6'd40: u = '{NIB_LO, BYTE_CLEAR, 1'b0, HOLD_2050, 1'b0};
            // display on
            6'd41: u = '{NIB_HI, BYTE_DCTL, 1'b0, HOLD_100, 1'b0};
            6'd42: u = '{NIB_HI, BYTE_DCTL, 1'b1, HOLD_100, 1'b0};
            6'd43: u = '{NIB_HI, BYTE_DCTL, 1'b0, HOLD_50,  1'b0};
            6'd44: u = '{NIB_LO, BYTE_DCTL, 1'b0, HOLD_100, 1'b0};
            6'd45: u = '{NIB_LO, BYTE_DCTL, 1'b1, HOLD_100, 1'b0};
            6'd46: u = '{NIB_LO, BYTE_DCTL, 1'b0, HOLD_50X, 1'b1};
            default: u = '{NIB_ZERO, BYTE_CMD, 1'b0, HOLD_100, 1'b1};
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/lcd4w_cmd_if.sv =====
// ----------------------------------------------------------------------------
// lcd4w_cmd_if
// Command request channel into the LCD write sequencer.
// ----------------------------------------------------------------------------
interface lcd4w_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  value;
    logic [6:0]  column;
    logic [6:0]  row;
    logic [10:0] extra_hold_us;

    modport source (output valid, op, value, column, row, extra_hold_us, input ready);
    modport sink   (input valid, op, value, column, row, extra_hold_us, output ready);
endinterface

// ===== rtl/lcd4w_pin_if.sv =====
// ----------------------------------------------------------------------------
// lcd4w_pin_if
// Pin-state request channel out of the LCD write sequencer.
// ----------------------------------------------------------------------------
interface lcd4w_pin_if;
    logic        valid;
    logic        ready;
    logic [3:0]  data_nibble;
    logic        reg_select;
    logic        enable;
    logic [14:0] hold_us;
    logic        last;

    modport source (output valid, data_nibble, reg_select, enable, hold_us, last,
                    input ready);
    modport sink   (input valid, data_nibble, reg_select, enable, hold_us, last,
                    output ready);
endinterface

// ===== rtl/lcd4w_cfg.sv =====
// ----------------------------------------------------------------------------
// lcd4w_cfg
// APB register file: line count and the three init command bytes.
// ----------------------------------------------------------------------------
module lcd4w_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcd4w_pkg::AddrW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lcd4w_pkg::t_cfg               o_cfg
);

    lcd4w_pkg::t_cfg r_cfg;
    logic [1:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_count          <= 3'd2;
            r_cfg.function_set_cmd    <= 8'h2C;
            r_cfg.display_control_cmd <= 8'h0C;
            r_cfg.entry_mode_cmd      <= 8'h06;
        end else if (wr_en) begin
            case (reg_idx)
                lcd4w_pkg::REG_LINE_COUNT: r_cfg.line_count          <= pwdata[2:0];
                lcd4w_pkg::REG_FUNC_SET:   r_cfg.function_set_cmd    <= pwdata[7:0];
                lcd4w_pkg::REG_DISP_CTL:   r_cfg.display_control_cmd <= pwdata[7:0];
                lcd4w_pkg::REG_ENTRY_MODE: r_cfg.entry_mode_cmd      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lcd4w_pkg::REG_LINE_COUNT: prdata = {29'd0, r_cfg.line_count};
            lcd4w_pkg::REG_FUNC_SET:   prdata = {24'd0, r_cfg.function_set_cmd};
            lcd4w_pkg::REG_DISP_CTL:   prdata = {24'd0, r_cfg.display_control_cmd};
            lcd4w_pkg::REG_ENTRY_MODE: prdata = {24'd0, r_cfg.entry_mode_cmd};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lcd4w_seq.sv =====
// ----------------------------------------------------------------------------
// lcd4w_seq
// Microcode step counter, ROM lookup and pin-state datapath.
// ----------------------------------------------------------------------------
`include "lcd_4bit_write_sequencer_assert.svh"

module lcd4w_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcd4w_pkg::t_cfg i_cfg,
    lcd4w_cmd_if.sink       i_cmd,
    lcd4w_pin_if.source     o_pin
);

    // control state
    logic        r_busy;
    logic [5:0]  r_pc;
    logic        r_ovalid;
    // latched request
    logic [7:0]  r_byte;
    logic        r_rs;
    logic [10:0] r_extra;
    // output payload
    logic [3:0]  r_nib;
    logic        r_ors;
    logic        r_oen;
    logic [14:0] r_hold;
    logic        r_olast;

    logic            cmd_acc;
    logic            adv;
    logic [5:0]      start_pc;
    logic [6:0]      row_off;
    logic [7:0]      cursor_byte;
    logic [7:0]      n_byte;
    lcd4w_pkg::t_uop uop;
    logic [7:0]      sel_byte;
    logic [3:0]      n_nib;
    logic [14:0]     n_hold;

    assign i_cmd.ready = !r_busy;
    assign cmd_acc     = i_cmd.valid && !r_busy;
    assign adv         = r_busy && (!r_ovalid || o_pin.ready);
    assign start_pc    = (i_cmd.op == lcd4w_pkg::OP_INIT) ? lcd4w_pkg::PcInit
                                                          : lcd4w_pkg::PcByte;

    // set-cursor address; rows 3/4 only map on displays with more than two lines
    always_comb begin
        row_off = i_cmd.row;
        if (i_cmd.row == 7'd1) begin
            row_off = lcd4w_pkg::Row1Off;
        end else if (i_cmd.row == 7'd2) begin
            row_off = lcd4w_pkg::Row2Off;
        end else if (i_cfg.line_count > 3'd2 && i_cmd.row == 7'd3) begin
            row_off = lcd4w_pkg::Row3Off;
        end else if (i_cfg.line_count > 3'd2 && i_cmd.row == 7'd4) begin
            row_off = lcd4w_pkg::Row4Off;
        end
        cursor_byte = lcd4w_pkg::SetDdram | ({1'b0, i_cmd.column} + {1'b0, row_off});
    end

    always_comb begin
        case (i_cmd.op)
            lcd4w_pkg::OP_CURSOR: n_byte = cursor_byte;
            default:              n_byte = i_cmd.value;
        endcase
    end

    assign uop = lcd4w_pkg::uop_rom(r_pc);

    always_comb begin
        case (uop.byte_sel)
            lcd4w_pkg::BYTE_CMD:   sel_byte = r_byte;
            lcd4w_pkg::BYTE_FSET:  sel_byte = i_cfg.function_set_cmd;
            lcd4w_pkg::BYTE_DOFF:  sel_byte = i_cfg.display_control_cmd
                                              & lcd4w_pkg::DispOffMask;
            lcd4w_pkg::BYTE_ENTRY: sel_byte = i_cfg.entry_mode_cmd;
            lcd4w_pkg::BYTE_CLEAR: sel_byte = lcd4w_pkg::ClearCmd;
            lcd4w_pkg::BYTE_DCTL:  sel_byte = i_cfg.display_control_cmd;
            default:               sel_byte = r_byte;
        endcase
    end

    always_comb begin
        case (uop.nib_sel)
            lcd4w_pkg::NIB_HI:   n_nib = sel_byte[7:4];
            lcd4w_pkg::NIB_LO:   n_nib = sel_byte[3:0];
            lcd4w_pkg::NIB_ZERO: n_nib = 4'h0;
            lcd4w_pkg::NIB_3:    n_nib = 4'h3;
            lcd4w_pkg::NIB_2:    n_nib = 4'h2;
            default:             n_nib = 4'h0;
        endcase
    end

    always_comb begin
        case (uop.hold_sel)
            lcd4w_pkg::HOLD_100:   n_hold = 15'd100;
            lcd4w_pkg::HOLD_50:    n_hold = 15'd50;
            lcd4w_pkg::HOLD_50X:   n_hold = 15'd50 + {4'd0, r_extra};
            lcd4w_pkg::HOLD_2050:  n_hold = 15'd2050;
            lcd4w_pkg::HOLD_20000: n_hold = 15'd20000;
            lcd4w_pkg::HOLD_5000:  n_hold = 15'd5000;
            lcd4w_pkg::HOLD_200:   n_hold = 15'd200;
            default:               n_hold = 15'd100;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (cmd_acc) begin
                r_busy <= 1'b1;
                r_pc   <= start_pc;
            end else if (adv) begin
                if (uop.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= r_pc + 6'd1;
                end
            end
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (o_pin.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_byte  <= n_byte;
            r_rs    <= (i_cmd.op == lcd4w_pkg::OP_DATA);
            r_extra <= i_cmd.extra_hold_us;
        end
        if (adv) begin
            r_nib   <= n_nib;
            r_ors   <= r_rs;
            r_oen   <= uop.en;
            r_hold  <= n_hold;
            r_olast <= uop.last;
        end
    end

    assign o_pin.valid       = r_ovalid;
    assign o_pin.data_nibble = r_nib;
    assign o_pin.reg_select  = r_ors;
    assign o_pin.enable      = r_oen;
    assign o_pin.hold_us     = r_hold;
    assign o_pin.last        = r_olast;

    `LCD4W_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, cmd_acc,
        r_busy && r_pc == $past(start_pc))
    `LCD4W_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, adv && uop.last,
        !r_busy && r_ovalid && r_olast)
    `LCD4W_ASSERT_IMPL(a_pc_range, i_clk, i_rst_n, r_busy, r_pc <= lcd4w_pkg::PcLast)

endmodule

// ===== rtl/lcd_4bit_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_4bit_write_sequencer
// Accept latches the command and the step counter; the first pin state is then
//   registered into the output register. Throughput: one pin state per cycle,
//   stalling while the output register is full and not taken; the input is held
//   busy from accept through all 6 states of a byte command, or 41 of init.
// Reset (synchronous, i_rst_n low) idles the sequencer and loads register
//   defaults: 2 lines, function set 0x2C, display control 0x0C, entry 0x06.
// ----------------------------------------------------------------------------
module lcd_4bit_write_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcd4w_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // command requests in, pin-state requests out
    lcd4w_cmd_if.sink                   i_cmd,
    lcd4w_pin_if.source                 o_pin
);

    // Register block. Writes must only happen while idle (the block does not enforce
    // this); the sequencer reads the registers live when it builds each pin state.
    lcd4w_pkg::t_cfg cfg;

    lcd4w_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer. A command picks a program entry (byte write or init); the
    // step counter walks the ROM one pin state per cycle into an output
    // register, stalling whenever that register is full and not taken.
    // Byte-write program: high nibble setup/strobe/release, then low nibble,
    // with the request's extra hold added to the final release.
    // Init program: 20 ms wait, three 0x3 wake-up strobes, 0x2 for 4-bit mode,
    // then function set, display off, entry mode, clear, display on.
    lcd4w_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_pin   (o_pin)
    );

endmodule
